// ===== rtl/core/egate_pkg.sv =====
// ----------------------------------------------------------------------------
// egate_pkg: shared types, constants and microcode for the noise gate
// Control word layout, program table, rounding helper and the exp table
// series used by the gate top level, its sequencer and its exp table.
// ----------------------------------------------------------------------------
package egate_pkg;

   localparam int EXP_DEPTH_DEF   = 256;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int AccW     = 72;   // MAC accumulator
   localparam int OpW      = 36;   // multiplier operands before the split
   localparam int SplitW   = 17;   // low half of the B operand
   localparam int StepW    = 6;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;
   localparam int ExpRomW  = 33;   // 2^-k/N in Q.32, entry 0 is exactly one

   localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
   localparam logic [63:0] LN2_Q32   = 64'd2977044472;
   localparam int          M_ONE     = 1 << 18;
   localparam logic [23:0] Q24_MAX   = 24'hFF_FFFF;

   localparam logic [31:0] ATTACK_RST   = 32'd1000000;
   localparam logic [31:0] RELEASE_RST  = 32'd1000000;
   localparam logic [23:0] CEILING_RST  = 24'd26527;
   localparam logic [31:0] SCALE_RST    = 32'd82897097;
   localparam logic [22:0] SHAPE_RST    = 23'd829000;
   localparam logic [23:0] OFFSET_RST   = 24'd710000;
   localparam logic [23:0] LEVEL_RST    = 24'd1070000;

   typedef enum logic [CsrIdxW-1:0] {
      REG_ATTACK  = 3'd0,
      REG_RELEASE = 3'd1,
      REG_CEILING = 3'd2,
      REG_SCALE   = 3'd3,
      REG_SHAPE   = 3'd4,
      REG_OFFSET  = 3'd5,
      REG_LEVEL   = 3'd6,
      REG_FOLLOW  = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      A_NONE, A_DELTA, A_ENV, A_M, A_X, A_F, A_REM, A_GDELTA, A_GAIN, A_LEFT, A_RIGHT
   } a_sel_type;

   typedef enum logic [3:0] {
      B_NONE, B_RATE, B_SCALE, B_SHAPE, B_LOG2E, B_DEPTH, B_DIFF, B_RELEASE, B_LEVEL, B_G
   } b_sel_type;

   typedef enum logic [1:0] {
      MAC_NONE, MAC_HI, MAC_LO
   } mac_type;

   typedef enum logic [4:0] {
      WB_NONE, WB_PREP, WB_ENV, WB_M, WB_X, WB_Y, WB_POS, WB_ROM_HI, WB_ROM_LO,
      WB_DIFF, WB_V, WB_SHAPE, WB_GDELTA, WB_GAIN, WB_G, WB_LEFT, WB_OUT_GATE,
      WB_GS, WB_OUT_FOL
   } wb_type;

   typedef enum logic [1:0] {
      JMP_NEXT, JMP_IF_FOLLOW, JMP_DONE
   } jmp_type;

   typedef struct packed {
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      mac_type           mac;
      wb_type            wb;
      jmp_type           jmp;
      logic [StepW-1:0]  target;
   } ctrl_word_type;

   typedef struct packed {
      logic          busy;
      logic          fire;
      ctrl_word_type word;
   } seq_out_type;

   localparam logic [StepW-1:0] STEP_FOLLOW = 6'd36;

   function automatic ctrl_word_type cw(input a_sel_type a, input b_sel_type b,
                                        input mac_type m, input wb_type w,
                                        input jmp_type j, input logic [StepW-1:0] t);
      ctrl_word_type c;
      c.a_sel  = a;
      c.b_sel  = b;
      c.mac    = m;
      c.wb     = w;
      c.jmp    = j;
      c.target = t;
      return c;
   endfunction

   // Program: every product takes a high pass and a low pass on the MAC.
   function automatic ctrl_word_type ucode(input logic [StepW-1:0] step);
      ctrl_word_type c;
      unique case (step)
         6'd0:  c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_PREP,     JMP_NEXT, '0);
         6'd1:  c = cw(A_DELTA,  B_RATE,    MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd2:  c = cw(A_DELTA,  B_RATE,    MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd3:  c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_ENV,      JMP_NEXT, '0);
         6'd4:  c = cw(A_ENV,    B_SCALE,   MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd5:  c = cw(A_ENV,    B_SCALE,   MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd6:  c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_M,        JMP_NEXT, '0);
         6'd7:  c = cw(A_M,      B_SHAPE,   MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd8:  c = cw(A_M,      B_SHAPE,   MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd9:  c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_X,        JMP_NEXT, '0);
         6'd10: c = cw(A_X,      B_LOG2E,   MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd11: c = cw(A_X,      B_LOG2E,   MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd12: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_Y,        JMP_NEXT, '0);
         6'd13: c = cw(A_F,      B_DEPTH,   MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd14: c = cw(A_F,      B_DEPTH,   MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd15: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_POS,      JMP_NEXT, '0);
         6'd16: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_ROM_HI,   JMP_NEXT, '0);
         6'd17: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_ROM_LO,   JMP_NEXT, '0);
         6'd18: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_DIFF,     JMP_NEXT, '0);
         6'd19: c = cw(A_REM,    B_DIFF,    MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd20: c = cw(A_REM,    B_DIFF,    MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd21: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_V,        JMP_NEXT, '0);
         6'd22: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_SHAPE,    JMP_NEXT, '0);
         6'd23: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_GDELTA,   JMP_NEXT, '0);
         6'd24: c = cw(A_GDELTA, B_RELEASE, MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd25: c = cw(A_GDELTA, B_RELEASE, MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd26: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_GAIN,     JMP_IF_FOLLOW,
                       STEP_FOLLOW);
         6'd27: c = cw(A_GAIN,   B_LEVEL,   MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd28: c = cw(A_GAIN,   B_LEVEL,   MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd29: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_G,        JMP_NEXT, '0);
         6'd30: c = cw(A_LEFT,   B_G,       MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd31: c = cw(A_LEFT,   B_G,       MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd32: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_LEFT,     JMP_NEXT, '0);
         6'd33: c = cw(A_RIGHT,  B_G,       MAC_HI,   WB_NONE,     JMP_NEXT, '0);
         6'd34: c = cw(A_RIGHT,  B_G,       MAC_LO,   WB_NONE,     JMP_NEXT, '0);
         6'd35: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_OUT_GATE, JMP_DONE, '0);
         6'd36: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_GS,       JMP_NEXT, '0);
         6'd37: c = cw(A_NONE,   B_NONE,    MAC_NONE, WB_OUT_FOL,  JMP_DONE, '0);
         default: c = cw(A_NONE, B_NONE,    MAC_NONE, WB_NONE,     JMP_DONE, '0);
      endcase
      return c;
   endfunction

   // v / 2^s, round to nearest, ties away from zero
   function automatic logic signed [AccW-1:0] rnd_away(input logic signed [AccW-1:0] v,
                                                       input int unsigned s);
      logic [AccW-1:0] mag;
      logic [AccW-1:0] q;
      mag = v[AccW-1] ? AccW'(-v) : AccW'(v);
      q   = (mag + (AccW'(1) << (s - 1))) >> s;
      return v[AccW-1] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [63:0] div_step(input logic [63:0] x, input logic [4:0] n);
      logic [63:0] q;
      unique case (n)
         5'd1:  q = x / 1;
         5'd2:  q = x / 2;
         5'd3:  q = x / 3;
         5'd4:  q = x / 4;
         5'd5:  q = x / 5;
         5'd6:  q = x / 6;
         5'd7:  q = x / 7;
         5'd8:  q = x / 8;
         5'd9:  q = x / 9;
         5'd10: q = x / 10;
         5'd11: q = x / 11;
         5'd12: q = x / 12;
         5'd13: q = x / 13;
         5'd14: q = x / 14;
         5'd15: q = x / 15;
         5'd16: q = x / 16;
         5'd17: q = x / 17;
         5'd18: q = x / 18;
         5'd19: q = x / 19;
         5'd20: q = x / 20;
         5'd21: q = x / 21;
         5'd22: q = x / 22;
         5'd23: q = x / 23;
         5'd24: q = x / 24;
         default: q = x;
      endcase
      return q;
   endfunction

   // exp(-a) in Q.32 by an alternating series up to the a^24 term, a in Q.32 (elaboration only)
   function automatic logic [ExpRomW-1:0] exp_series(input logic [63:0] a);
      logic [63:0] term;
      logic [63:0] sum;
      term = 64'd1 << 32;
      sum  = 64'd1 << 32;
      for (int n = 1; n <= 24; n++) begin
         term = div_step((term * a) >> 32, 5'(n));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum[ExpRomW-1:0];
   endfunction

endpackage

// ===== rtl/core/egate_seq.sv =====
// ----------------------------------------------------------------------------
// egate_seq: microcode sequencer
// Step counter over the program table, with a follower-mode branch and a
// hold on the last step while the output register is still occupied.
// ----------------------------------------------------------------------------
module egate_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                follow,
   input  logic                stall,
   output egate_pkg::seq_out_type seq
);
   import egate_pkg::*;

   logic             busy_ff, busy_in;
   logic [StepW-1:0] step_ff, step_in;
   ctrl_word_type    word;
   logic             fire;

   always_comb begin
      word    = ucode(step_ff);
      fire    = busy_ff & ~stall;
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (fire) begin
         unique case (word.jmp)
            JMP_DONE:      busy_in = 1'b0;
            JMP_IF_FOLLOW: step_in = follow ? word.target : step_ff + 1'b1;
            default:       step_in = step_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign seq.busy = busy_ff;
   assign seq.fire = fire;
   assign seq.word = word;

endmodule

// ===== rtl/core/egate_exp_rom.sv =====
// ----------------------------------------------------------------------------
// egate_exp_rom: power-of-two fraction table
// Entry k holds 2^(-k/EXP_TABLE_DEPTH) in Q.32; registered read port.
// ----------------------------------------------------------------------------
module egate_exp_rom #(
   parameter int EXP_TABLE_DEPTH = egate_pkg::EXP_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic [$clog2(EXP_TABLE_DEPTH+1)-1:0] addr,
   output logic [egate_pkg::ExpRomW-1:0]         rom_q
);
   import egate_pkg::*;

   logic [ExpRomW-1:0] table_w [0:EXP_TABLE_DEPTH];
   logic [ExpRomW-1:0] rom_q_ff;

   for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_entry
      // k * ln2 / depth, rounded
      localparam logic [63:0] ARG =
         (64'(k) * LN2_Q32 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
      assign table_w[k] = exp_series(ARG);
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= table_w[addr];
   end

   assign rom_q = rom_q_ff;

endmodule

// ===== rtl/core/expander_noise_gate.sv =====
// ----------------------------------------------------------------------------
// expander_noise_gate: stereo noise gate / expander
// Envelope follower, exponential gain shaper with table interpolation,
// smoothed gain, and gate or follower output, run by a microcoded sequencer
// over one shared multiply-accumulate unit.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata: sample_left, sample_right
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: result_left, result_right
//   csr      in   csr_we                 csr_index, csr_wdata
//
// Gate mode runs the program up to the gate output; follower mode branches after
// the gain update, past the level and sample multiplies. Each product goes
// through the single 36x19 MAC in two passes, high half of B then low half.
// Reset is synchronous: registers load their defaults, envelope and gain
// clear, sequencer goes idle.
// req_tready is low while the program runs; the last step holds while the
// output register still carries an untaken transaction.
// ----------------------------------------------------------------------------
module expander_noise_gate #(
   parameter int EXP_TABLE_DEPTH = egate_pkg::EXP_DEPTH_DEF,
   parameter int SAMPLE_BITS     = egate_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // sample_left, sample_right
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // result_left, result_right
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   input  logic                                   csr_we,
   input  logic [egate_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [egate_pkg::CsrDataW-1:0]         csr_wdata
);
   import egate_pkg::*;

   localparam int SB      = SAMPLE_BITS;
   localparam int MW      = (SB > 24) ? SB : 24;
   localparam int DeltaW  = MW + 1;
   localparam int DataW   = ((2 * SB + 7) / 8) * 8;
   localparam int IdxW    = $clog2(EXP_TABLE_DEPTH);
   localparam int AddrW   = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int ShR     = (SB < 25) ? (25 - SB) : 0;
   localparam int ShL     = (SB > 25) ? (SB - 25) : 0;
   localparam int GsHalf  = (1 << ShR) >> 1;

   // configuration
   logic [31:0] attack_ff, release_ff, scale_ff;
   logic [23:0] ceiling_ff, offset_ff, level_ff;
   logic [22:0] shape_ff;
   logic        follow_ff;

   // state
   logic [23:0] env_ff, env_in;
   logic [23:0] gain_ff, gain_in;

   // datapath
   logic signed [SB-1:0]     l_ff, r_ff;
   logic signed [DeltaW-1:0] delta_ff, delta_in;
   logic                     rate_up_ff, rate_up_in;
   logic signed [19:0]       m_ff, m_in;
   logic [29:0]              x_ff, x_in;
   logic [23:0]              f_ff;
   logic [4:0]               n_ff;
   logic                     zero_ff, zero_in;
   logic [IdxW-1:0]          idx_ff, idx_in;
   logic [23:0]              rem_ff;
   logic [ExpRomW-1:0]       hi_ff, diff_ff, v_ff, v_in;
   logic [23:0]              shaped_ff, shaped_in;
   logic signed [24:0]       gdelta_ff, gdelta_in;
   logic [28:0]              g_ff, g_in;
   logic [SB-1:0]            resl_ff, resl_in;
   logic [31:0]              gs_ff, gs_in;
   logic signed [AccW-1:0]   acc_ff, acc_in;
   logic [SB-1:0]            out_l_ff, out_r_ff, out_l_in, out_r_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [OpW-1:0]     op_a, op_b;
   logic signed [OpW-SplitW-1:0] b_part;
   logic signed [OpW+OpW-SplitW-1:0] prod;

   logic [AccW-1:0]         acc_u, mq, yq, pq, tq, gsw;
   logic signed [AccW-1:0]  rnd32, rnd24, rnd12, env_sum, gain_sum, gs_s;
   logic [SB-1:0]           abs_l, abs_r;
   logic [SB:0]             abs_sum;
   logic [24:0]             ex;
   logic signed [25:0]      sd;
   logic [AddrW-1:0]        rom_addr;
   logic [ExpRomW-1:0]      rom_q;

   seq_out_type seq;
   logic        accept, stall, done;

   function automatic logic [SB-1:0] sat_sb(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] hi;
      logic signed [AccW-1:0] lo;
      hi = $signed((AccW'(1) << (SB - 1)) - AccW'(1));
      lo = ~hi;
      if (v > hi) begin
         return hi[SB-1:0];
      end else if (v < lo) begin
         return lo[SB-1:0];
      end
      return v[SB-1:0];
   endfunction

   // ---------------------------------------------------------------- control
   assign accept     = req_tvalid & req_tready;
   assign req_tready = ~seq.busy;
   assign stall      = (seq.word.jmp == JMP_DONE) & rsp_valid_ff & ~rsp_tready;
   assign done       = seq.fire & (seq.word.jmp == JMP_DONE);

   egate_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .follow (follow_ff),
      .stall  (stall),
      .seq    (seq)
   );

   assign rom_addr = (seq.word.wb == WB_ROM_LO) ? AddrW'(idx_ff) + AddrW'(1)
                                                 : AddrW'(idx_ff);

   egate_exp_rom #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .rom_q (rom_q)
   );

   // ---------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= ATTACK_RST;
         release_ff <= RELEASE_RST;
         ceiling_ff <= CEILING_RST;
         scale_ff   <= SCALE_RST;
         shape_ff   <= SHAPE_RST;
         offset_ff  <= OFFSET_RST;
         level_ff   <= LEVEL_RST;
         follow_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_ATTACK:  attack_ff  <= csr_wdata;
            REG_RELEASE: release_ff <= csr_wdata;
            REG_CEILING: ceiling_ff <= csr_wdata[23:0];
            REG_SCALE:   scale_ff   <= csr_wdata;
            REG_SHAPE:   shape_ff   <= csr_wdata[22:0];
            REG_OFFSET:  offset_ff  <= csr_wdata[23:0];
            REG_LEVEL:   level_ff   <= csr_wdata[23:0];
            REG_FOLLOW:  follow_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------- MAC
   always_comb begin
      unique case (seq.word.a_sel)
         A_DELTA:  op_a = {{(OpW-DeltaW){delta_ff[DeltaW-1]}}, delta_ff};
         A_ENV:    op_a = OpW'(env_ff);
         A_M:      op_a = {{(OpW-20){m_ff[19]}}, m_ff};
         A_X:      op_a = OpW'(x_ff);
         A_F:      op_a = OpW'(f_ff);
         A_REM:    op_a = OpW'(rem_ff);
         A_GDELTA: op_a = {{(OpW-25){gdelta_ff[24]}}, gdelta_ff};
         A_GAIN:   op_a = OpW'(gain_ff);
         A_LEFT:   op_a = {{(OpW-SB){l_ff[SB-1]}}, l_ff};
         A_RIGHT:  op_a = {{(OpW-SB){r_ff[SB-1]}}, r_ff};
         default:  op_a = '0;
      endcase
      unique case (seq.word.b_sel)
         B_RATE:    op_b = OpW'(rate_up_ff ? attack_ff : release_ff);
         B_SCALE:   op_b = OpW'(scale_ff);
         B_SHAPE:   op_b = OpW'(shape_ff);
         B_LOG2E:   op_b = OpW'(LOG2E_Q30);
         B_DEPTH:   op_b = OpW'(EXP_TABLE_DEPTH);
         B_DIFF:    op_b = OpW'(diff_ff);
         B_RELEASE: op_b = OpW'(release_ff);
         B_LEVEL:   op_b = OpW'(level_ff);
         B_G:       op_b = OpW'(g_ff);
         default:   op_b = '0;
      endcase
      // high pass takes the signed upper part, low pass the unsigned lower part
      b_part = (seq.word.mac == MAC_HI) ? op_b[OpW-1:SplitW]
                                        : $signed({2'b00, op_b[SplitW-1:0]});
      prod   = op_a * b_part;
      acc_in = (seq.word.mac == MAC_LO) ? (acc_ff <<< SplitW) + AccW'(prod)
                                        : AccW'(prod);
   end

   // -------------------------------------------------------- write-back math
   always_comb begin
      acc_u   = $unsigned(acc_ff);
      rnd32   = rnd_away(acc_ff, 32);
      rnd24   = rnd_away(acc_ff, 24);
      rnd12   = rnd_away(acc_ff, 12);

      // mean level and envelope error
      abs_l      = l_ff[SB-1] ? SB'(~l_ff + 1'b1) : SB'(l_ff);
      abs_r      = r_ff[SB-1] ? SB'(~r_ff + 1'b1) : SB'(r_ff);
      abs_sum    = {1'b0, abs_l} + {1'b0, abs_r};
      delta_in   = $signed({{(DeltaW-SB){1'b0}}, abs_sum[SB:1]})
                 - $signed({{(DeltaW-24){1'b0}}, env_ff});
      rate_up_in = ~delta_in[DeltaW-1] & (|delta_in);

      env_sum = $signed({{(AccW-24){1'b0}}, env_ff}) + rnd32;
      env_in  = (env_sum > $signed({{(AccW-24){1'b0}}, ceiling_ff})) ? ceiling_ff
                                                                     : env_sum[23:0];

      // exponent argument; a positive value gives exactly one later on
      mq   = (acc_u + (AccW'(1) << (SB - 2))) >> (SB - 1);
      m_in = (mq > AccW'(M_ONE)) ? '0 : $signed(mq[19:0] - 20'(M_ONE));

      x_in = rnd12[AccW-1] ? 30'(-rnd12) : '0;

      yq      = (acc_u + (AccW'(1) << 29)) >> 30;
      zero_in = |yq[AccW-1:29];

      pq     = acc_u >> 24;
      idx_in = (pq >= AccW'(EXP_TABLE_DEPTH)) ? IdxW'(EXP_TABLE_DEPTH - 1)
                                              : pq[IdxW-1:0];

      tq   = (acc_u + (AccW'(1) << 23)) >> 24;
      v_in = (hi_ff - tq[ExpRomW-1:0]) >> n_ff;

      ex        = zero_ff ? '0 : 25'((v_ff + ExpRomW'(128)) >> 8);
      sd        = $signed({1'b0, ex}) - $signed({2'b00, offset_ff});
      shaped_in = sd[25] ? '0 : (sd[24] ? Q24_MAX : sd[23:0]);

      gdelta_in = $signed({1'b0, shaped_ff}) - $signed({1'b0, gain_ff});

      gain_sum = $signed({{(AccW-24){1'b0}}, gain_ff}) + rnd32;
      gain_in  = gain_sum[23:0];

      g_in    = 29'((acc_u + (AccW'(1) << 19)) >> 20);
      resl_in = sat_sb(rnd24);

      gsw   = ((AccW'(gain_ff) + AccW'(GsHalf)) >> ShR) << ShL;
      gs_in = gsw[31:0];
      gs_s  = $signed(AccW'(gs_ff));

      if (seq.word.wb == WB_OUT_FOL) begin
         out_l_in = sat_sb(gs_s);
         out_r_in = sat_sb($signed({{(AccW-SB){r_ff[SB-1]}}, r_ff}) + gs_s);
      end else begin
         out_l_in = resl_ff;
         out_r_in = sat_sb(rnd24);
      end

      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // -------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (accept) begin
         l_ff <= req_tdata[SB-1:0];
         r_ff <= req_tdata[2*SB-1:SB];
      end
      if (seq.fire && seq.word.mac != MAC_NONE) begin
         acc_ff <= acc_in;
      end
      if (seq.fire) begin
         unique case (seq.word.wb)
            WB_PREP: begin
               delta_ff   <= delta_in;
               rate_up_ff <= rate_up_in;
            end
            WB_M:      m_ff <= m_in;
            WB_X:      x_ff <= x_in;
            WB_Y: begin
               zero_ff <= zero_in;
               n_ff    <= yq[28:24];
               f_ff    <= yq[23:0];
            end
            WB_POS: begin
               idx_ff <= idx_in;
               rem_ff <= acc_u[23:0];
            end
            WB_ROM_LO: hi_ff     <= rom_q;
            WB_DIFF:   diff_ff   <= hi_ff - rom_q;
            WB_V:      v_ff      <= v_in;
            WB_SHAPE:  shaped_ff <= shaped_in;
            WB_GDELTA: gdelta_ff <= gdelta_in;
            WB_G:      g_ff      <= g_in;
            WB_LEFT:   resl_ff   <= resl_in;
            WB_GS:     gs_ff     <= gs_in;
            WB_OUT_GATE, WB_OUT_FOL: begin
               out_l_ff <= out_l_in;
               out_r_ff <= out_r_in;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff       <= '0;
         gain_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (seq.fire && seq.word.wb == WB_ENV) begin
            env_ff <= env_in;
         end
         if (seq.fire && seq.word.wb == WB_GAIN) begin
            gain_ff <= gain_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DataW'({out_r_ff, out_l_ff});

   // ------------------------------------------------------------- assertions
   a_valid_from_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done))
      else $error("result valid raised without a finished program");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> seq.busy)
      else $error("sequencer not running after an accepted sample pair");

   a_env_clamped: assert property (@(posedge clock) disable iff (reset)
      (seq.fire && seq.word.wb == WB_ENV) |=> (env_ff <= ceiling_ff))
      else $error("envelope above ceiling after update");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the stereo noise gate / expander
// Streams sample pairs through the gate under several register settings
// and compares every output pair against a bit-accurate in-bench
// predictor of the envelope, exponential shaper and smoothed gain.
// ----------------------------------------------------------------------------
module tb_top;
   import egate_pkg::*;

   typedef longint unsigned u64_t;

   typedef struct packed {
      logic [23:0] right;
      logic [23:0] left;
   } stereo_pair_t;

   localparam int     DATA_W      = 48;
   localparam int     EXP_DEPTH   = 256;
   localparam int     QUIET_LIMIT = 4000;
   localparam longint LOG2E_Q30   = 64'd1549082005;
   localparam u64_t   LN2_Q32     = 64'd2977044472;
   localparam longint GAIN_MAX    = 64'd16777215;
   localparam longint SAMPLE_MAX  = 64'd8388607;
   localparam longint SAMPLE_MIN  = -64'sd8388608;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;
   logic                csr_we     = 1'b0;
   csr_index_type       csr_index  = REG_ATTACK;
   logic [CsrDataW-1:0] csr_wdata  = '0;

   expander_noise_gate u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // predictor copy of the registers, reset values
   longint attack_q32  = 1000000;
   longint release_q32 = 1000000;
   longint env_ceiling = 26527;
   longint thr_scale   = 82897097;
   longint shape_q18   = 829000;
   longint shape_off   = 710000;
   longint out_level   = 1070000;
   bit     follow_mode = 1'b0;
   // predictor state
   longint env_level   = 0;
   longint gain_q24    = 0;
   longint pow2_rom [0:EXP_DEPTH];

   stereo_pair_t predicted_outputs [$];
   int  mismatches      = 0;
   int  outputs_seen    = 0;
   int  pairs_sent      = 0;
   int  settings_loaded = 0;
   bit  idle_on         = 1'b1;
   int  hold_request    = 0;

   // v / 2^s, nearest, ties away from zero
   function automatic longint round_q(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >> s;
      return -((-v + half) >> s);
   endfunction

   function automatic longint saturate24(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   function automatic stereo_pair_t predict_gate_output(input logic signed [23:0] in_l,
                                                        input logic signed [23:0] in_r);
      longint l, r, mean, delta, rate, p, m, e24, x, y, n, f;
      longint pos, idx, rem, hi, lo, v, ex, shaped, g, gs;
      stereo_pair_t res;
      l = in_l;
      r = in_r;
      mean  = ((l < 0 ? -l : l) + (r < 0 ? -r : r)) >> 1;
      delta = mean - env_level;
      rate  = (delta > 0) ? attack_q32 : release_q32;
      env_level = env_level + round_q(rate * delta, 32);
      if (env_level > env_ceiling) env_level = env_ceiling;

      p   = env_level * thr_scale;
      m   = ((p + (longint'(1) << 22)) >> 23) - (longint'(1) << 18);
      e24 = round_q(shape_q18 * m, 12);
      x   = (e24 < 0) ? -e24 : 0;   // positive exponent clamps to exp(0)

      // exp(-x) = 2^-(x*log2e): integer part shifts, fraction interpolates the table
      y = (x * LOG2E_Q30 + (longint'(1) << 29)) >> 30;
      n = y >> 24;
      f = y & 64'hFF_FFFF;
      if (n >= 32) begin
         ex = 0;
      end else begin
         pos = f * EXP_DEPTH;
         idx = pos >> 24;
         rem = pos & 64'hFF_FFFF;
         if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
         hi = pow2_rom[idx];
         lo = pow2_rom[idx + 1];
         v  = hi - (((hi - lo) * rem + (longint'(1) << 23)) >> 24);
         v  = v >> n;
         ex = (v + 128) >> 8;
      end

      shaped = ex - shape_off;
      if (shaped < 0) shaped = 0;
      if (shaped > GAIN_MAX) shaped = GAIN_MAX;
      gain_q24 = gain_q24 + round_q(release_q32 * (shaped - gain_q24), 32);

      if (follow_mode) begin
         gs = (gain_q24 + 1) >> 1;
         res.left  = 24'(saturate24(gs));
         res.right = 24'(saturate24(r + gs));
      end else begin
         g = (gain_q24 * out_level + (longint'(1) << 19)) >> 20;
         res.left  = 24'(saturate24(round_q(l * g, 24)));
         res.right = 24'(saturate24(round_q(r * g, 24)));
      end
      return res;
   endfunction

   function automatic void note_mismatch(input string field, input logic [23:0] want,
                                         input logic [23:0] got);
      if (mismatches < 10)
         $display("mismatch %s on output %0d: expected %0d, got %0d", field, outputs_seen,
                  $signed(want), $signed(got));
      mismatches++;
   endfunction

   task automatic check_output(input stereo_pair_t got);
      stereo_pair_t want;
      if (predicted_outputs.size() == 0) begin
         if (mismatches < 10)
            $display("output transaction with no sample pair outstanding: %h", got);
         mismatches++;
      end else begin
         want = predicted_outputs.pop_front();
         if (got.left !== want.left) note_mismatch("result_left", want.left, got.left);
         if (got.right !== want.right) note_mismatch("result_right", want.right, got.right);
      end
      outputs_seen++;
   endtask

   // output side: checks transactions, random stalls, long hold on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) check_output(stereo_pair_t'(rsp_tdata));
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(99) < 21) begin
            rsp_tready <= 1'b0;
            if ($urandom_range(29) == 0) hold_left = $urandom_range(40, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("no transaction for %0d cycles, %0d outputs still pending", quiet,
                     predicted_outputs.size());
            $display("[expander_noise_gate] ERROR");
            $finish;
         end
      end
   end

   // valid stays high on return; settle() or an idle gap in the next call drops it
   task automatic send_pair(input logic signed [23:0] left, input logic signed [23:0] right);
      int gap;
      if (idle_on && $urandom_range(99) < 21) begin
         gap = ($urandom_range(19) == 0) ? $urandom_range(45, 1) : $urandom_range(3, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      do @(posedge clock); while (!req_tready);
      predicted_outputs.push_back(predict_gate_output(left, right));
      pairs_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predicted_outputs.size() != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_ATTACK:  attack_q32  = val;
         REG_RELEASE: release_q32 = val;
         REG_CEILING: env_ceiling = val[23:0];
         REG_SCALE:   thr_scale   = val;
         REG_SHAPE:   shape_q18   = val[22:0];
         REG_OFFSET:  shape_off   = val[23:0];
         REG_LEVEL:   out_level   = val[23:0];
         REG_FOLLOW:  follow_mode = val[0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [31:0] att, input logic [31:0] rel,
                               input logic [31:0] ceil, input logic [31:0] scl,
                               input logic [31:0] shp, input logic [31:0] off,
                               input logic [31:0] lvl, input logic [31:0] fol);
      settle();
      write_csr(REG_ATTACK, att);
      write_csr(REG_RELEASE, rel);
      write_csr(REG_CEILING, ceil);
      write_csr(REG_SCALE, scl);
      write_csr(REG_SHAPE, shp);
      write_csr(REG_OFFSET, off);
      write_csr(REG_LEVEL, lvl);
      write_csr(REG_FOLLOW, fol);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // random amplitude shifted down, with occasional corner values (full scale, zero, +1, -1)
   function automatic logic signed [23:0] shaped_noise(input int shift);
      logic signed [23:0] raw;
      raw = 24'($urandom);
      if ($urandom_range(99) < 8) begin
         case ($urandom_range(4))
            0:       raw = 24'sh7FFFFF;
            1:       raw = 24'sh800000;
            2:       raw = 24'sh000000;
            3:       raw = -24'sd1;
            default: raw = 24'sd1;
         endcase
         return raw;
      end
      return raw >>> shift;
   endfunction

   // bursts of a common loudness so the envelope both climbs and decays
   task automatic run_noise_phase(input int count);
      int shift, burst;
      shift = 0;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            shift = $urandom_range(23);
            burst = $urandom_range(40, 4);
         end
         burst--;
         if ($urandom_range(99) < 2) settle();
         send_pair(shaped_noise(shift), shaped_noise(shift));
      end
   endtask

   task automatic test_reset_defaults();
      send_pair(24'sh000000, 24'sh000000);
      send_pair(24'sh7FFFFF, 24'sh7FFFFF);
      send_pair(24'sh800000, 24'sh800000);
      send_pair(24'sh800000, 24'sh7FFFFF);
      send_pair(24'sh7FFFFF, 24'sh800000);
      send_pair(24'sd1, -24'sd1);
      send_pair(-24'sd1, 24'sd1);
      send_pair(24'sh000000, 24'sh000000);
   endtask

   task automatic test_exponent_corners();
      // zero shape: exp(0) is exactly one, shaped gain clamps to its top
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8388608, 32'd82897097, 32'd0, 32'd0,
                   32'hFF_FFFF, 32'd0);
      send_pair(24'sh7FFFFF, 24'sh800000);
      send_pair(24'sh400000, -24'sh400000);
      // envelope*scale above one: exponent forced to zero; follower saturates
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8388608, 32'hFFFF_FFFF, 32'h7F_FFFF,
                   32'd710000, 32'd1048576, 32'd1);
      send_pair(24'sh800000, 24'sh800000);
      send_pair(24'sh7FFFFF, 24'sh7FFFFF);
      send_pair(24'sh000000, 24'sh7FFFFF);
      // zero scale, steep shape: power-of-two shift past 31, offset clamps shaped gain to zero
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h7F_FFFF, 32'hFF_FFFF,
                   32'hFF_FFFF, 32'd0);
      send_pair(24'sh7FFFFF, 24'sh7FFFFF);
      send_pair(24'sh000010, -24'sh000010);
      send_pair(24'sh800000, 24'sh000000);
      // zero rates freeze envelope and gain
      program_regs(32'd0, 32'd0, 32'd26527, 32'd82897097, 32'd829000, 32'd710000,
                   32'd1070000, 32'd1);
      send_pair(24'sh7FFFFF, 24'sh800000);
      send_pair(24'sh000000, 24'sh7FFFFF);
      // oversized writes: only the register's own bits are kept
      program_regs(32'h8000_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'd262144, 32'hFFFF_FFFF,
                   32'hFF00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_pair(24'sh7FFFFF, 24'sh7FFFFF);
      send_pair(-24'sh123456, 24'sh654321);
   endtask

   task automatic test_output_backpressure();
      program_regs(32'h1000_0000, 32'h0800_0000, 32'd26527, 32'd82897097, 32'd829000,
                   32'd710000, 32'd1070000, 32'd0);
      hold_request = 400;
      for (int i = 0; i < 8; i++) send_pair(24'($urandom), 24'($urandom));
      settle();
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: program_regs(32'd1000000, 32'd1000000, 32'd26527, 32'd82897097, 32'd829000,
                            32'd710000, 32'd1070000, 32'd0);
            1: program_regs(32'd1000000, 32'd1000000, 32'd26527, 32'd82897097, 32'd829000,
                            32'd710000, 32'd1070000, 32'd1);
            2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8388608, 32'd262144,
                            32'h7F_FFFF, 32'd0, 32'hFF_FFFF, 32'd0);
            3: program_regs(32'h0010_0000, 32'h0001_0000, 32'd26527, 32'd2621440000,
                            32'd262144, 32'hFF_FFFF, 32'd0, 32'd1);
            5: program_regs(32'h4000_0000, 32'h0800_0000, $urandom_range(8388608),
                            $urandom_range(2621440000, 262144),
                            $urandom_range(8388607, 262144), $urandom_range(16777215),
                            $urandom_range(16777215), $urandom_range(1));
            default: program_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
         endcase
         idle_on = (ph != 7);   // last phase runs back to back
         run_noise_phase(205);
      end
      idle_on = 1'b1;
   endtask

   initial begin : main
      u64_t a, term, total;
      for (int k = 0; k <= EXP_DEPTH; k++) begin
         a = (u64_t'(k) * LN2_Q32 + EXP_DEPTH / 2) / EXP_DEPTH;
         term  = u64_t'(1) << 32;
         total = term;
         for (int n = 1; n <= 24; n++) begin
            term = ((term * a) >> 32) / u64_t'(n);
            if (n % 2 == 1) total = total - term;
            else total = total + term;
         end
         pow2_rom[k] = longint'(total);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_exponent_corners();
      test_output_backpressure();
      test_random_settings();

      settle();
      repeat (40) @(posedge clock);
      $display("%0d sample pairs over %0d register settings, %0d outputs checked",
               pairs_sent, settings_loaded, outputs_seen);
      $display("gate and follower modes, exponent clamps, long output stall, %0d mismatches",
               mismatches);
      if (mismatches == 0 && predicted_outputs.size() == 0) begin
         $display("[expander_noise_gate] OK");
      end else begin
         $display("[expander_noise_gate] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/egate_pkg.sv
rtl/core/egate_seq.sv
rtl/core/egate_exp_rom.sv
rtl/core/expander_noise_gate.sv
tb/tb_top.sv
